### hdl/irms_pkg.sv
// ----------------------------------------------------------------------------
// irms_pkg
// Shared types and codes for the ir mark/space sequencer.
// ----------------------------------------------------------------------------
package irms_pkg;

  // item kind carried on the func field
  localparam logic FUNC_WAVE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // segment word: carrier flag above a 16-bit duration
  localparam int unsigned DUR_W = 16;
  localparam int unsigned SEG_W = DUR_W + 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BUSY_REJ  = 2'd1,
    ST_EMPTY_REJ = 2'd2
  } status_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APP_MARK,
    S_APP_SPACE,
    S_START,
    S_LOAD,
    S_RESP
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic         capture;
    logic         append_mark;
    logic         append_space;
    logic         dec_ticks;
    logic         start_play;
    logic         fetch;
    logic         fetch_first;
    logic         load_seg;
    logic         finish;
    logic         set_status;
    status_code_t status_code;
  } irms_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic func_tick;
    logic last_wave;
    logic busy_flag;
    logic rem_gt1;
    logic play_end;
    logic fill_zero;
  } irms_stat_t;

endpackage

### hdl/irms_ram.sv
// ----------------------------------------------------------------------------
// irms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module irms_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/irms_ctrl.sv
// ----------------------------------------------------------------------------
// irms_ctrl
// Sequencing state machine: decodes one item and steps the datapath.
// ----------------------------------------------------------------------------
module irms_ctrl
  import irms_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_valid,
  input  irms_stat_t stat,
  output irms_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.func_tick) begin
          if (stat.busy_flag) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ST_BUSY_REJ;
            state_nxt       = S_RESP;
          end else begin
            state_nxt = S_APP_MARK;
          end
        end else if (!stat.busy_flag) begin
          state_nxt = S_RESP;
        end else if (stat.rem_gt1) begin
          cmd.dec_ticks = 1'b1;
          state_nxt     = S_RESP;
        end else if (stat.play_end) begin
          cmd.finish = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          cmd.fetch = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_APP_MARK: begin
        cmd.append_mark = 1'b1;
        state_nxt       = S_APP_SPACE;
      end
      S_APP_SPACE: begin
        cmd.append_space = 1'b1;
        state_nxt        = S_START;
      end
      S_START: begin
        if (!stat.last_wave) begin
          state_nxt = S_RESP;
        end else if (stat.fill_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_EMPTY_REJ;
          state_nxt       = S_RESP;
        end else begin
          cmd.start_play  = 1'b1;
          cmd.fetch       = 1'b1;
          cmd.fetch_first = 1'b1;
          state_nxt       = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_seg = 1'b1;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/irms_dp.sv
// ----------------------------------------------------------------------------
// irms_dp
// Segment store, fill/play counters, tick counter and result registers.
// ----------------------------------------------------------------------------
module irms_dp
  import irms_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 80
) (
  input  logic               clk,
  input  logic               rst_n,
  input  irms_cmd_t          cmd,
  output irms_stat_t         stat,
  input  logic               in_func,
  input  logic [DUR_W-1:0]   in_mark_len,
  input  logic [DUR_W-1:0]   in_space_len,
  input  logic               in_last_wave,
  output logic               out_carrier_gate,
  output logic               out_busy_res,
  output logic [1:0]         out_status,
  output logic               out_done_res
);

  localparam int unsigned AW    = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  // captured item
  logic             func_r;
  logic [DUR_W-1:0] mark_r;
  logic [DUR_W-1:0] space_r;
  logic             last_r;

  // playback state
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] play_r;
  logic [DUR_W-1:0] rem_r;
  logic             busy_flag_r;
  logic             carrier_r;
  status_code_t     status_r;
  logic             done_r;

  logic             we;
  logic [SEG_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [SEG_W-1:0] rdata;
  logic             has_room;

  assign has_room = (fill_r < CNT_MAX);

  always_comb begin
    we    = 1'b0;
    wdata = {1'b0, space_r};
    if (cmd.append_mark) begin
      we    = (mark_r != '0) && has_room;
      wdata = {1'b1, mark_r};
    end else if (cmd.append_space) begin
      we    = (space_r != '0) && has_room;
      wdata = {1'b0, space_r};
    end
  end

  assign raddr = cmd.fetch_first ? '0 : play_r[AW-1:0];

  irms_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (we),
    .waddr (fill_r[AW-1:0]),
    .wdata (wdata),
    .re    (cmd.fetch),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      mark_r  <= in_mark_len;
      space_r <= in_space_len;
      last_r  <= in_last_wave;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      play_r      <= '0;
      rem_r       <= '0;
      busy_flag_r <= 1'b0;
      carrier_r   <= 1'b0;
      status_r    <= ST_OK;
      done_r      <= 1'b0;
    end else begin
      if (cmd.capture) begin
        status_r <= ST_OK;
        done_r   <= 1'b0;
      end
      if (cmd.set_status) begin
        status_r <= cmd.status_code;
      end
      if (we) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.dec_ticks) begin
        rem_r <= rem_r - 1'b1;
      end
      if (cmd.start_play) begin
        busy_flag_r <= 1'b1;
        play_r      <= '0;
      end
      if (cmd.load_seg) begin
        carrier_r <= rdata[SEG_W-1];
        rem_r     <= rdata[DUR_W-1:0];
        play_r    <= play_r + 1'b1;
      end
      if (cmd.finish) begin
        carrier_r   <= 1'b0;
        busy_flag_r <= 1'b0;
        rem_r       <= '0;
        fill_r      <= '0;
        play_r      <= '0;
        done_r      <= 1'b1;
      end
    end
  end

  always_comb begin
    stat.func_tick = (func_r == FUNC_TICK);
    stat.last_wave = last_r;
    stat.busy_flag = busy_flag_r;
    stat.rem_gt1   = (rem_r > DUR_W'(1));
    stat.play_end  = (play_r >= fill_r);
    stat.fill_zero = (fill_r == '0);
  end

  assign out_carrier_gate = carrier_r;
  assign out_busy_res     = busy_flag_r;
  assign out_status       = status_r;
  assign out_done_res     = done_r;

endmodule

### hdl/ir_mark_space_sequencer.sv
// ----------------------------------------------------------------------------
// ir_mark_space_sequencer
// Loads mark/space pairs into a segment store and plays them as a carrier gate.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+-------------------
//  input     | in_func, in_mark_len, in_space_len, in_last_wave | start & !busy
//  result    | out_carrier_gate, out_busy_res, out_status,    | out_valid, 1 cycle
//            | out_done_res                                   |
//
//  - after acceptance a wave rejected as busy or a tick that loads no segment
//    goes from decode to the response, a tick that loads the next segment
//    fetches and loads it first, and a wave appends its mark, then its space,
//    and fetches and loads the first segment when it starts playback; the
//    steps follow from the segment store's single write port and registered read
//  - busy stays high until the cycle after the out_valid strobe, so the next
//    item is taken at the earliest in that cycle
//  - rst_n is synchronous; it clears counters, flags and the controller but
//    not the segment store, whose entries are only read below the fill count
//  - the receiver cannot stall: a result is presented for exactly one cycle
//
module ir_mark_space_sequencer
  import irms_pkg::*;
#(
  parameter int unsigned MAX_SEGMENTS = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  // input item
  input  logic             start,
  output logic             busy,
  input  logic             in_func,
  input  logic [DUR_W-1:0] in_mark_len,
  input  logic [DUR_W-1:0] in_space_len,
  input  logic             in_last_wave,
  // result item
  output logic             out_valid,
  output logic             out_carrier_gate,
  output logic             out_busy_res,
  output logic [1:0]       out_status,
  output logic             out_done_res
);

  irms_cmd_t  cmd;
  irms_stat_t stat;

  // controller: decodes the captured item and walks the datapath through
  // append, start, fetch and response steps
  irms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: segment ram, counters and the result registers
  irms_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_func          (in_func),
    .in_mark_len      (in_mark_len),
    .in_space_len     (in_space_len),
    .in_last_wave     (in_last_wave),
    .out_carrier_gate (out_carrier_gate),
    .out_busy_res     (out_busy_res),
    .out_status       (out_status),
    .out_done_res     (out_done_res)
  );

endmodule

### hdl/irms_checker.sv
// ----------------------------------------------------------------------------
// irms_checker
// Port-level checks for the ir mark/space sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module irms_checker
  import irms_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_carrier_gate,
  input logic       out_busy_res,
  input logic [1:0] out_status,
  input logic       out_done_res
);

  // an accepted item keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  // a result only appears inside the busy window and ends it
  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside busy window");

  a_result_releases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result strobe");

  // end of transmission leaves carrier off and the channel idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_carrier_gate)
    else $error("done with carrier or busy still set");

  // rejections come from waves, done from ticks
  a_status_no_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_done_res)
    else $error("done reported with a reject status");

endmodule

bind ir_mark_space_sequencer irms_checker u_irms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_carrier_gate (out_carrier_gate),
  .out_busy_res     (out_busy_res),
  .out_status       (out_status),
  .out_done_res     (out_done_res)
);
